### hw/rtl/pcdt_pkg.sv
`timescale 1ns / 1ps
package pcdt_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int ACC_WIDTH = PROD_WIDTH + 3;

    localparam logic [1:0] OP_COEF = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] CFG_LIMIT = 2'd0;
    localparam logic [1:0] CFG_TOTAL = 2'd1;
    localparam logic [1:0] CFG_INTENSITY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_coef;
        logic div_start;
        logic div_step;
        logic restart_done;
        logic restart_stop;
        logic point_take;
        logic mul_step;
        logic [1:0] mul_col;
        logic fin_step;
        logic out_load;
    } pcdt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cfg_zero;
        logic stopped;
        logic phase_zero;
        logic div_done;
    } pcdt_status_t;
endpackage

### hw/rtl/point_cloud_decimate_transform_top.sv
`timescale 1ns / 1ps
// Decimating rigid transform for point streams. A pose word loads one
// coefficient; a point that is skipped or dropped produces no result.
// A kept point runs three multiply passes (one column of the
// rotation per cycle on three row multipliers), a round and translate step
// and a saturate step into the output register. A restart with a zero limit
// or total stops the stream; otherwise a bit-serial divider computes the
// stride. Input is held while a result waits in the output register.
module point_cloud_decimate_transform_top (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [1:0] op,
    input  logic [3:0] coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] src_x,
    input  logic signed [31:0] src_y,
    input  logic signed [31:0] src_z,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic signed [31:0] world_z,
    output logic [7:0] intensity,
    output logic limit_reached,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    pcdt_pkg::pcdt_cmd_t cmd;
    pcdt_pkg::pcdt_status_t status;

    assign cfg_ready = 1'b1;

    pcdt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .cmd(cmd)
    );

    pcdt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .coef_index(coef_index), .coef_value(coef_value),
        .src_x(src_x), .src_y(src_y), .src_z(src_z), .cmd(cmd), .status(status),
        .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .intensity(intensity), .limit_reached(limit_reached)
    );

    // no input taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted with result pending");
    // result held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(world_x))
        else $error("result dropped");
    // a new result only goes into an empty output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid)
        else $error("output overwritten");
endmodule

### hw/rtl/pcdt_ctrl.sv
`timescale 1ns / 1ps
module pcdt_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [1:0] op,
    output logic out_valid,
    input  logic out_ready,
    input  pcdt_pkg::pcdt_status_t status,
    output pcdt_pkg::pcdt_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_FIN = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] col_reg, col_next;
    logic out_valid_reg, out_valid_next;
    logic acc;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign acc = in_valid && in_ready;

    // sequencing
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        col_next = col_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.mul_col = col_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (op)
                        pcdt_pkg::OP_COEF: cmd.load_coef = 1'b1;
                        pcdt_pkg::OP_RESTART:
                        begin
                            if (status.cfg_zero)
                                cmd.restart_stop = 1'b1;
                            else
                            begin
                                cmd.div_start = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        pcdt_pkg::OP_POINT:
                        begin
                            if (!status.stopped)
                            begin
                                cmd.point_take = 1'b1;
                                if (status.phase_zero)
                                begin
                                    col_next = 2'd0;
                                    state_next = S_MUL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.restart_done = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd2)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin_step = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

### hw/rtl/pcdt_datapath.sv
`timescale 1ns / 1ps
module pcdt_datapath (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [3:0] coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] src_x,
    input  logic signed [31:0] src_y,
    input  logic signed [31:0] src_z,
    input  pcdt_pkg::pcdt_cmd_t cmd,
    output pcdt_pkg::pcdt_status_t status,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic signed [31:0] world_z,
    output logic [7:0] intensity,
    output logic limit_reached
);
    localparam int CW = pcdt_pkg::COORD_WIDTH;
    localparam int AW = pcdt_pkg::ACC_WIDTH;
    localparam int IW = (CW < 32) ? CW : 32;
    localparam logic signed [CW-1:0] ONE_Q =
        (pcdt_pkg::FRAC_BITS < CW - 1) ? CW'(64'sd1 <<< pcdt_pkg::FRAC_BITS)
                                       : CW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] MAX_C = CW'((65'sd1 <<< (CW - 1)) - 65'sd1);
    localparam logic signed [CW-1:0] MIN_C = ~MAX_C;

    logic [23:0] limit_reg;
    logic [31:0] total_reg;
    logic [7:0] inten_reg;
    logic signed [CW-1:0] coef_reg [12];
    logic [31:0] stride_reg, phase_reg;
    logic [23:0] count_reg;
    logic stopped_reg;
    logic signed [CW-1:0] pt_reg [3];
    logic signed [AW-1:0] acc_reg [3];
    logic signed [CW-1:0] res_reg [3];
    logic signed [pcdt_pkg::PROD_WIDTH-1:0] prod [3];
    logic [31:0] quo_reg, rem_reg, num_reg;
    logic [5:0] div_cnt_reg;
    logic [31:0] phase_inc;
    logic [23:0] count_inc;
    logic [32:0] rem_try;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            total_reg <= '0;
            inten_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pcdt_pkg::CFG_LIMIT: limit_reg <= cfg_data[23:0];
                pcdt_pkg::CFG_TOTAL: total_reg <= cfg_data;
                pcdt_pkg::CFG_INTENSITY: inten_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pose coefficients
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
                coef_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
        end
        else if (cmd.load_coef && coef_index < 4'd12)
            coef_reg[coef_index] <= CW'($signed(coef_value[IW-1:0]));
    end

    // restoring divider, ceil(total / limit) taken as floor((total - 1) / limit) + 1
    assign rem_try = {rem_reg, num_reg[31]} - {9'd0, limit_reg};
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= total_reg - 32'd1;
            rem_reg <= '0;
            quo_reg <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[30:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (!rem_try[32])
            begin
                rem_reg <= rem_try[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], num_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    // decimation state
    assign phase_inc = phase_reg + 32'd1;
    assign count_inc = count_reg + 24'd1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= 32'd1;
            phase_reg <= '0;
            count_reg <= '0;
            stopped_reg <= 1'b1;
        end
        else
        begin
            if (cmd.restart_stop || cmd.div_start)
            begin
                phase_reg <= '0;
                count_reg <= '0;
                stopped_reg <= 1'b1;
            end
            if (cmd.restart_done)
            begin
                stride_reg <= (total_reg > {8'd0, limit_reg}) ? quo_reg + 32'd1 : 32'd1;
                stopped_reg <= 1'b0;
            end
            if (cmd.point_take)
                phase_reg <= (phase_inc >= stride_reg) ? 32'd0 : phase_inc;
            if (cmd.out_load)
            begin
                count_reg <= count_inc;
                if (count_inc >= limit_reg)
                    stopped_reg <= 1'b1;
            end
        end
    end

    // full-width products of the current column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            prod[r] = coef_reg[r * 3 + int'(cmd.mul_col)] * pt_reg[cmd.mul_col];
    end

    // transform: one column of products per cycle, three rows in lanes
    always_ff @(posedge clk)
    begin
        if (cmd.point_take)
        begin
            pt_reg[0] <= CW'($signed(src_x[IW-1:0]));
            pt_reg[1] <= CW'($signed(src_y[IW-1:0]));
            pt_reg[2] <= CW'($signed(src_z[IW-1:0]));
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= AW'(64'sd1 <<< (pcdt_pkg::FRAC_BITS - 1));
        end
        else if (cmd.mul_step)
        begin
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= acc_reg[r] + AW'(prod[r]);
        end
        else if (cmd.fin_step)
        begin
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= (acc_reg[r] >>> pcdt_pkg::FRAC_BITS)
                              + AW'(coef_reg[9 + r]);
        end
    end

    // saturation and output word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (acc_reg[r] > AW'(MAX_C))
                    res_reg[r] <= MAX_C;
                else if (acc_reg[r] < AW'(MIN_C))
                    res_reg[r] <= MIN_C;
                else
                    res_reg[r] <= acc_reg[r][CW-1:0];
            end
            intensity <= inten_reg;
            limit_reached <= count_inc >= limit_reg;
        end
    end

    assign world_x = 32'($signed(res_reg[0]));
    assign world_y = 32'($signed(res_reg[1]));
    assign world_z = 32'($signed(res_reg[2]));

    assign status.cfg_zero = (limit_reg == '0) || (total_reg == '0);
    assign status.stopped = stopped_reg;
    assign status.phase_zero = phase_reg == 32'd0;
    assign status.div_done = div_cnt_reg == 6'd32;
endmodule
